// ----- src/triangle_midpoint_subdivide_normalize_macros.svh -----
// assertion macros shared by the subdivision block
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDE_NORMALIZE_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDE_NORMALIZE_MACROS_SVH

// same-cycle implication
`define TMSN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tmsn_pkg.sv -----
// types, point codes and emit order for the subdivision block
`default_nettype none
package tmsn_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_SEND
   } seq_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SQUARE,
      NS_INIT,
      NS_BIT,
      NS_DONE
   } norm_state_type;

   typedef enum logic [2:0] {
      PT_V0,
      PT_V1,
      PT_V2,
      PT_M01,
      PT_M02,
      PT_M12
   } point_type;

   localparam int NUM_OUT_VERTS = 12;
   localparam logic [3:0] LAST_IDX = 4'(NUM_OUT_VERTS - 1);

   // four triangles: (v0,m01,m02) (m01,v1,m12) (v2,m02,m12) (m01,m12,m02)
   function automatic point_type point_of(input logic [3:0] idx);
      point_type pt;
      case (idx)
         4'd0:    pt = PT_V0;
         4'd1:    pt = PT_M01;
         4'd2:    pt = PT_M02;
         4'd3:    pt = PT_M01;
         4'd4:    pt = PT_V1;
         4'd5:    pt = PT_M12;
         4'd6:    pt = PT_V2;
         4'd7:    pt = PT_M02;
         4'd8:    pt = PT_M12;
         4'd9:    pt = PT_M01;
         4'd10:   pt = PT_M12;
         4'd11:   pt = PT_M02;
         default: pt = PT_V0;
      endcase
      return pt;
   endfunction

endpackage
`default_nettype wire

// ----- src/tmsn_norm.sv -----
// iterative unit-length scaler: squares through one multiplier, then bit-serial search
`default_nettype none
module tmsn_norm #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [COORD_BITS-1:0] in_x,
   input  wire logic signed [COORD_BITS-1:0] in_y,
   input  wire logic signed [COORD_BITS-1:0] in_z,
   output logic                              done,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic signed [COORD_BITS-1:0]      out_z
);
   localparam int C  = COORD_BITS;
   localparam int F  = C - 2;
   localparam int QW = C - 1;
   localparam int SW = 2 * C + 2;
   localparam int W  = 4 * C + 4;
   localparam int JW = $clog2(F + 1);

   tmsn_pkg::norm_state_type state_ff, state_in;
   logic [1:0]          ax_ff, ax_in;
   logic                neg_ff [3], neg_in [3];
   logic [C-1:0]        mag_ff [3], mag_in [3];
   logic [2*C-1:0]      sq_ff [3], sq_in [3];
   logic [SW-1:0]       s_ff, s_in;
   logic signed [W-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [QW-1:0]       q_ff, q_in;
   logic [JW-1:0]       j_ff, j_in;
   logic signed [C-1:0] res_ff [3], res_in [3];

   logic signed [C-1:0] vin [3];
   logic [C-1:0]        mag_sel;
   logic [2*C-1:0]      prod;
   logic signed [W-1:0] s_ext, a_try;
   logic                take;
   logic [QW-1:0]       q_bit, q_fin;

   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   assign mag_sel = mag_ff[ax_ff];
   assign prod    = (2*C)'(mag_sel) * (2*C)'(mag_sel);
   assign s_ext   = signed'(W'(s_ff));
   // (2q-1)^2 * s for the trial bit, kept incrementally
   assign a_try   = a_ff + (b_ff <<< (int'(j_ff) + 2)) + (s_ext <<< (2 * int'(j_ff) + 2));
   assign take    = !q_ff[QW-1] && (a_try <= r_ff);
   assign q_bit   = QW'(1) << j_ff;
   assign q_fin   = take ? (q_ff | q_bit) : q_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmsn_pkg::NS_IDLE:   if (start) state_in = tmsn_pkg::NS_SQUARE;
         tmsn_pkg::NS_SQUARE: if (ax_ff == 2'd2) state_in = tmsn_pkg::NS_INIT;
         tmsn_pkg::NS_INIT:   state_in = tmsn_pkg::NS_BIT;
         tmsn_pkg::NS_BIT: begin
            if (j_ff == '0) begin
               state_in = (ax_ff == 2'd2) ? tmsn_pkg::NS_DONE : tmsn_pkg::NS_INIT;
            end
         end
         tmsn_pkg::NS_DONE:   state_in = tmsn_pkg::NS_IDLE;
         default:             state_in = tmsn_pkg::NS_IDLE;
      endcase
   end

   always_comb begin
      ax_in = ax_ff;
      s_in  = s_ff;
      a_in  = a_ff;
      b_in  = b_ff;
      r_in  = r_ff;
      q_in  = q_ff;
      j_in  = j_ff;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = neg_ff[i];
         mag_in[i] = mag_ff[i];
         sq_in[i]  = sq_ff[i];
         res_in[i] = res_ff[i];
      end
      case (state_ff)
         tmsn_pkg::NS_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vin[i][C-1];
                  mag_in[i] = vin[i][C-1] ? C'(-vin[i]) : C'(vin[i]);
               end
               s_in  = '0;
               ax_in = '0;
            end
         end
         tmsn_pkg::NS_SQUARE: begin
            sq_in[ax_ff] = prod;
            s_in  = s_ff + SW'(prod);
            ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         tmsn_pkg::NS_INIT: begin
            a_in = s_ext;
            b_in = -s_ext;
            q_in = '0;
            j_in = JW'(F);
            r_in = signed'(W'(sq_ff[ax_ff]) << (2 * F + 2));
         end
         tmsn_pkg::NS_BIT: begin
            if (take) begin
               q_in = q_ff | q_bit;
               a_in = a_try;
               b_in = b_ff + (s_ext <<< (int'(j_ff) + 1));
            end
            if (j_ff == '0) begin
               // zero vector stays zero
               if (s_ff == '0) begin
                  res_in[ax_ff] = '0;
               end else if (neg_ff[ax_ff]) begin
                  res_in[ax_ff] = -signed'(C'(q_fin));
               end else begin
                  res_in[ax_ff] = signed'(C'(q_fin));
               end
               ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end else begin
               j_in = j_ff - JW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmsn_pkg::NS_IDLE;
         ax_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
      end
      s_ff <= s_in;
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
      q_ff <= q_in;
      j_ff <= j_in;
      for (int i = 0; i < 3; i++) begin
         neg_ff[i] <= neg_in[i];
         mag_ff[i] <= mag_in[i];
         sq_ff[i]  <= sq_in[i];
         res_ff[i] <= res_in[i];
      end
   end

   assign done  = (state_ff == tmsn_pkg::NS_DONE);
   assign out_x = res_ff[0];
   assign out_y = res_ff[1];
   assign out_z = res_ff[2];

endmodule
`default_nettype wire

// ----- src/triangle_midpoint_subdivide_normalize.sv -----
// top level: vertex store, midpoint select, emit sequencer and result register
//
// usage
//   req_* takes one vertex per item (signed position, unsigned color and texcoord).
//   the first two vertices of a triangle are stored and give no result; req_ready
//   stays high for them.
//   the third vertex starts a run of twelve result items on rsp_*, four triangles
//   (v0,m01,m02) (m01,v1,m12) (v2,m02,m12) (m01,m12,m02); rsp_last_vertex marks
//   the twelfth.
//   every emitted vertex goes through the shared scaler, which squares the three
//   axes on one multiplier and then runs a bit-serial search per axis; the
//   result then waits in the result register for rsp_ready.
//   req_ready is low from the third vertex until the last result is taken.
//   a stalled receiver simply holds the result register; nothing is lost.
//   reset empties the vertex store count and drops any run in progress.
`default_nettype none
`include "triangle_midpoint_subdivide_normalize_macros.svh"
module triangle_midpoint_subdivide_normalize #(
   parameter int COORD_BITS = 16,
   parameter int ATTR_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [COORD_BITS-1:0] req_pos_y,
   input  wire logic signed [COORD_BITS-1:0] req_pos_z,
   input  wire logic [ATTR_BITS-1:0]         req_color_r,
   input  wire logic [ATTR_BITS-1:0]         req_color_g,
   input  wire logic [ATTR_BITS-1:0]         req_color_b,
   input  wire logic [ATTR_BITS-1:0]         req_color_a,
   input  wire logic [ATTR_BITS-1:0]         req_tex_u,
   input  wire logic [ATTR_BITS-1:0]         req_tex_v,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_out_pos_x,
   output logic signed [COORD_BITS-1:0]      rsp_out_pos_y,
   output logic signed [COORD_BITS-1:0]      rsp_out_pos_z,
   output logic [ATTR_BITS-1:0]              rsp_out_color_r,
   output logic [ATTR_BITS-1:0]              rsp_out_color_g,
   output logic [ATTR_BITS-1:0]              rsp_out_color_b,
   output logic [ATTR_BITS-1:0]              rsp_out_color_a,
   output logic [ATTR_BITS-1:0]              rsp_out_tex_u,
   output logic [ATTR_BITS-1:0]              rsp_out_tex_v,
   output logic                              rsp_last_vertex
);
   localparam int C = COORD_BITS;
   localparam int A = ATTR_BITS;

   tmsn_pkg::seq_state_type state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic [3:0] idx_ff, idx_in;

   // vertex store: slots 0 and 1 hold v0, v1; slot 2 takes v2
   logic signed [C-1:0] pos_ff [3][3], pos_in [3][3];
   logic [A-1:0]        attr_ff [3][6], attr_in [3][6];

   logic signed [C-1:0] cur_pos [3];
   logic [A-1:0]        cur_attr [6];
   logic signed [C-1:0] sel_pos [3];
   logic [A-1:0]        sel_attr [6];
   tmsn_pkg::point_type pt;

   logic signed [C-1:0] out_pos_ff [3], out_pos_in [3];
   logic [A-1:0]        out_attr_ff [6], out_attr_in [6];
   logic                last_ff, last_in;

   logic                req_take, rsp_take;
   logic                norm_start, norm_done;
   logic signed [C-1:0] norm_x, norm_y, norm_z;

   // floor of half the sum, signed and unsigned
   function automatic logic signed [C-1:0] mid_pos(input logic signed [C-1:0] u,
                                                   input logic signed [C-1:0] w);
      logic signed [C:0] sum;
      sum = (C+1)'(u) + (C+1)'(w);
      return sum[C:1];
   endfunction

   function automatic logic [A-1:0] mid_attr(input logic [A-1:0] u, input logic [A-1:0] w);
      logic [A:0] sum;
      sum = (A+1)'(u) + (A+1)'(w);
      return sum[A:1];
   endfunction

   assign cur_pos[0]  = req_pos_x;
   assign cur_pos[1]  = req_pos_y;
   assign cur_pos[2]  = req_pos_z;
   assign cur_attr[0] = req_color_r;
   assign cur_attr[1] = req_color_g;
   assign cur_attr[2] = req_color_b;
   assign cur_attr[3] = req_color_a;
   assign cur_attr[4] = req_tex_u;
   assign cur_attr[5] = req_tex_v;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // point for the vertex being emitted
   assign pt = tmsn_pkg::point_of(idx_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (pt)
            tmsn_pkg::PT_V0:  sel_pos[i] = pos_ff[0][i];
            tmsn_pkg::PT_V1:  sel_pos[i] = pos_ff[1][i];
            tmsn_pkg::PT_V2:  sel_pos[i] = pos_ff[2][i];
            tmsn_pkg::PT_M01: sel_pos[i] = mid_pos(pos_ff[0][i], pos_ff[1][i]);
            tmsn_pkg::PT_M02: sel_pos[i] = mid_pos(pos_ff[0][i], pos_ff[2][i]);
            tmsn_pkg::PT_M12: sel_pos[i] = mid_pos(pos_ff[1][i], pos_ff[2][i]);
            default:          sel_pos[i] = pos_ff[0][i];
         endcase
      end
      for (int i = 0; i < 6; i++) begin
         case (pt)
            tmsn_pkg::PT_V0:  sel_attr[i] = attr_ff[0][i];
            tmsn_pkg::PT_V1:  sel_attr[i] = attr_ff[1][i];
            tmsn_pkg::PT_V2:  sel_attr[i] = attr_ff[2][i];
            tmsn_pkg::PT_M01: sel_attr[i] = mid_attr(attr_ff[0][i], attr_ff[1][i]);
            tmsn_pkg::PT_M02: sel_attr[i] = mid_attr(attr_ff[0][i], attr_ff[2][i]);
            tmsn_pkg::PT_M12: sel_attr[i] = mid_attr(attr_ff[1][i], attr_ff[2][i]);
            default:          sel_attr[i] = attr_ff[0][i];
         endcase
      end
   end

   tmsn_norm #(
      .COORD_BITS(C)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .in_x  (sel_pos[0]),
      .in_y  (sel_pos[1]),
      .in_z  (sel_pos[2]),
      .done  (norm_done),
      .out_x (norm_x),
      .out_y (norm_y),
      .out_z (norm_z)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmsn_pkg::ST_IDLE:  if (req_take && slot_ff == 2'd2) state_in = tmsn_pkg::ST_START;
         tmsn_pkg::ST_START: state_in = tmsn_pkg::ST_WAIT;
         tmsn_pkg::ST_WAIT:  if (norm_done) state_in = tmsn_pkg::ST_SEND;
         tmsn_pkg::ST_SEND: begin
            if (rsp_take) begin
               state_in = (idx_ff == tmsn_pkg::LAST_IDX) ? tmsn_pkg::ST_IDLE
                                                         : tmsn_pkg::ST_START;
            end
         end
         default:            state_in = tmsn_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = (state_ff == tmsn_pkg::ST_IDLE);
      rsp_valid  = (state_ff == tmsn_pkg::ST_SEND);
      norm_start = (state_ff == tmsn_pkg::ST_START);
   end

   // store, counters and result register
   always_comb begin
      slot_in = slot_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 3; i++) pos_in[s][i] = pos_ff[s][i];
         for (int i = 0; i < 6; i++) attr_in[s][i] = attr_ff[s][i];
      end
      for (int i = 0; i < 3; i++) out_pos_in[i] = out_pos_ff[i];
      for (int i = 0; i < 6; i++) out_attr_in[i] = out_attr_ff[i];

      if (req_take) begin
         for (int i = 0; i < 3; i++) pos_in[slot_ff][i] = cur_pos[i];
         for (int i = 0; i < 6; i++) attr_in[slot_ff][i] = cur_attr[i];
         slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
         idx_in  = '0;
      end

      if (state_ff == tmsn_pkg::ST_WAIT && norm_done) begin
         out_pos_in[0] = norm_x;
         out_pos_in[1] = norm_y;
         out_pos_in[2] = norm_z;
         for (int i = 0; i < 6; i++) out_attr_in[i] = sel_attr[i];
         last_in = (idx_ff == tmsn_pkg::LAST_IDX);
      end

      if (rsp_take && idx_ff != tmsn_pkg::LAST_IDX) idx_in = idx_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmsn_pkg::ST_IDLE;
         slot_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         idx_ff   <= idx_in;
      end
      last_ff <= last_in;
      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 3; i++) pos_ff[s][i] <= pos_in[s][i];
         for (int i = 0; i < 6; i++) attr_ff[s][i] <= attr_in[s][i];
      end
      for (int i = 0; i < 3; i++) out_pos_ff[i] <= out_pos_in[i];
      for (int i = 0; i < 6; i++) out_attr_ff[i] <= out_attr_in[i];
   end

   assign rsp_out_pos_x   = out_pos_ff[0];
   assign rsp_out_pos_y   = out_pos_ff[1];
   assign rsp_out_pos_z   = out_pos_ff[2];
   assign rsp_out_color_r = out_attr_ff[0];
   assign rsp_out_color_g = out_attr_ff[1];
   assign rsp_out_color_b = out_attr_ff[2];
   assign rsp_out_color_a = out_attr_ff[3];
   assign rsp_out_tex_u   = out_attr_ff[4];
   assign rsp_out_tex_v   = out_attr_ff[5];
   assign rsp_last_vertex = last_ff;

   // no new vertex while a run of results is out
   `TMSN_ASSERT_NOW(a_no_overlap, clock, reset, req_ready, !rsp_valid, "input taken during emit")
   // last flag only on the twelfth result
   `TMSN_ASSERT_NOW(a_last_idx, clock, reset, rsp_valid && rsp_last_vertex,
                    idx_ff == tmsn_pkg::LAST_IDX, "last flag on wrong vertex")
   // scaler finishes only when the sequencer waits for it
   `TMSN_ASSERT_NOW(a_done_wait, clock, reset, norm_done,
                    state_ff == tmsn_pkg::ST_WAIT, "scaler done out of turn")
   // a started scaler run always leads to a wait
   `TMSN_ASSERT_NEXT(a_start_wait, clock, reset, norm_start,
                     state_ff == tmsn_pkg::ST_WAIT, "start not followed by wait")

endmodule
`default_nettype wire

// ----- tb/tb_triangle_midpoint_subdivide_normalize.sv -----
// testbench for the triangle subdivision and sphere projection block
`timescale 1ns / 1ps
`default_nettype none
module tb_triangle_midpoint_subdivide_normalize;

   localparam int CB = 16;
   localparam int AB = 16;
   localparam int NUM_ATTR = 6;
   localparam int FRAC = CB - 2;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_START = 4000;
   localparam int HOLD_CYCLES = 1500;
   localparam int RANDOM_ITEMS = 400;

   // one vertex as it enters or leaves the block
   typedef struct {
      logic signed [CB-1:0] p[3];
      logic [AB-1:0]        a[NUM_ATTR];
   } vertex_type;

   typedef struct {
      vertex_type v;
      logic       last;
   } emitted_type;

   // holds the first two vertices of a triangle and the queue of emitted vertices
   class subdivide_scoreboard;
      vertex_type  held[2];
      int          slot;
      emitted_type pending[$];
      int          errors;

      function new();
         slot = 0;
         errors = 0;
      endfunction

      task report(input string what, input int got, input int want);
         $display("mismatch %s: got %0d expected %0d (%0d pending)",
                  what, got, want, pending.size());
         errors++;
      endtask

      // nearest integer to |p| * 2^FRAC / sqrt(s), ties away from zero, with the sign of p
      function automatic logic [CB-1:0] scale_axis(input int signed p,
                                                   input longint unsigned s);
         longint unsigned mag, rhs, lo, hi, mid, d;
         mag = (p < 0) ? longint'(-p) : longint'(p);
         if (mag == 0 || s == 0) return '0;
         rhs = (mag * mag) << (2 * FRAC + 2);
         lo = 0;
         hi = 64'd1 << FRAC;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            d = 2 * mid - 1;
            if (d * d * s <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return (p < 0) ? CB'(-lo) : CB'(lo);
      endfunction

      function automatic vertex_type project(input vertex_type v);
         vertex_type o;
         longint unsigned s;
         longint signed c;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            c = v.p[i];
            s += longint'(c * c);
         end
         o = v;
         for (int i = 0; i < 3; i++) o.p[i] = scale_axis(int'(v.p[i]), s);
         return o;
      endfunction

      // floor of half the sum, signed for position, unsigned for attributes
      function automatic vertex_type halfway(input vertex_type u, input vertex_type w);
         vertex_type m;
         logic signed [CB:0] ps;
         logic [AB:0] as_;
         for (int i = 0; i < 3; i++) begin
            ps = (CB+1)'(u.p[i]) + (CB+1)'(w.p[i]);
            m.p[i] = CB'(ps >>> 1);
         end
         for (int i = 0; i < NUM_ATTR; i++) begin
            as_ = {1'b0, u.a[i]} + {1'b0, w.a[i]};
            m.a[i] = as_[AB:1];
         end
         return m;
      endfunction

      function void note_vertex(input vertex_type v);
         vertex_type m01, m02, m12;
         vertex_type order[12];
         emitted_type e;
         if (slot < 2) begin
            held[slot] = v;
            slot++;
            return;
         end
         slot = 0;
         m01 = halfway(held[0], held[1]);
         m02 = halfway(held[0], v);
         m12 = halfway(held[1], v);
         order = '{held[0], m01, m02, m01, held[1], m12, v, m02, m12, m01, m12, m02};
         for (int i = 0; i < 12; i++) begin
            e.v = project(order[i]);
            e.last = (i == 11);
            pending.push_back(e);
         end
      endfunction

      task check_result(input emitted_type got);
         emitted_type want;
         if (pending.size() == 0) begin
            report("unexpected item", 0, 0);
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 3; i++)
            if (got.v.p[i] !== want.v.p[i])
               report($sformatf("pos[%0d]", i), int'(got.v.p[i]), int'(want.v.p[i]));
         for (int i = 0; i < NUM_ATTR; i++)
            if (got.v.a[i] !== want.v.a[i])
               report($sformatf("attr[%0d]", i), int'(got.v.a[i]), int'(want.v.a[i]));
         if (got.last !== want.last) report("last_vertex", got.last, want.last);
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_last_vertex;
   logic signed [CB-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [AB-1:0] req_color_r, req_color_g, req_color_b, req_color_a, req_tex_u, req_tex_v;
   logic signed [CB-1:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic [AB-1:0] rsp_out_color_r, rsp_out_color_g, rsp_out_color_b, rsp_out_color_a;
   logic [AB-1:0] rsp_out_tex_u, rsp_out_tex_v;

   subdivide_scoreboard board;
   int cycles;
   int sent;
   bit stimulus_done;

   triangle_midpoint_subdivide_normalize dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_color_r, .req_color_g, .req_color_b, .req_color_a,
      .req_tex_u, .req_tex_v,
      .rsp_valid, .rsp_ready,
      .rsp_out_pos_x, .rsp_out_pos_y, .rsp_out_pos_z,
      .rsp_out_color_r, .rsp_out_color_g, .rsp_out_color_b, .rsp_out_color_a,
      .rsp_out_tex_u, .rsp_out_tex_v, .rsp_last_vertex
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle counter doubles as the watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // idle with a chance of 38 in 100 per call, except in the quiet window from lo to hi
   function automatic bit want_idle(input int pos, input int lo, input int hi);
      if (pos >= lo && pos < hi) return 1'b0;
      return $urandom_range(99) < 38;
   endfunction

   // receiver: random stalls, one long hold-off so the block backs up
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_CYCLES)
            rsp_ready = 1'b0;
         else
            rsp_ready = !want_idle(cycles, 20000, 35000);
      end
   end

   // result monitor, sampled at the rising edge
   always @(posedge clock) begin
      emitted_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.v.p = '{rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z};
         r.v.a = '{rsp_out_color_r, rsp_out_color_g, rsp_out_color_b,
                   rsp_out_color_a, rsp_out_tex_u, rsp_out_tex_v};
         r.last = rsp_last_vertex;
         board.check_result(r);
      end
   end

   // offer one vertex, hold it until taken; valid stays high into the next item unless it idles first
   task send_vertex(input vertex_type v);
      while (want_idle(sent, 150, 260)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      {req_pos_x, req_pos_y, req_pos_z} = {v.p[0], v.p[1], v.p[2]};
      {req_color_r, req_color_g, req_color_b, req_color_a, req_tex_u, req_tex_v} =
         {v.a[0], v.a[1], v.a[2], v.a[3], v.a[4], v.a[5]};
      do @(posedge clock); while (!req_ready);
      board.note_vertex(v);
      sent++;
      @(negedge clock);
   endtask

   function automatic vertex_type make_vertex(input int x, input int y, input int z,
                                              input int attr);
      vertex_type v;
      v.p = '{CB'(x), CB'(y), CB'(z)};
      for (int i = 0; i < NUM_ATTR; i++) v.a[i] = AB'(attr);
      return v;
   endfunction

   // random vertex: mostly full range, some small or axis-aligned to hit rounding
   function automatic vertex_type random_vertex();
      vertex_type v;
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         if (kind < 6) v.p[i] = CB'($urandom);
         else if (kind < 8) v.p[i] = CB'($urandom_range(128) - 64);
         else v.p[i] = ($urandom_range(2) == 0) ? CB'($urandom) : '0;
      end
      for (int i = 0; i < NUM_ATTR; i++) v.a[i] = AB'($urandom);
      return v;
   endfunction

   initial begin
      board = new();
      cycles = 0;
      sent = 0;
      stimulus_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_pos_x, req_pos_y, req_pos_z} = '0;
      {req_color_r, req_color_g, req_color_b, req_color_a, req_tex_u, req_tex_v} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes of every field, zero vector, unit axes, mixed signs
      send_vertex(make_vertex(32767, 32767, 32767, 16'hffff));
      send_vertex(make_vertex(-32768, -32768, -32768, 0));
      send_vertex(make_vertex(0, 0, 0, 16'h8000));
      send_vertex(make_vertex(0, 0, 0, 0));
      send_vertex(make_vertex(0, 0, 0, 16'hffff));
      send_vertex(make_vertex(1, 0, 0, 1));
      send_vertex(make_vertex(16384, 0, 0, 16'h5555));
      send_vertex(make_vertex(0, -16384, 0, 16'haaaa));
      send_vertex(make_vertex(0, 0, 16384, 16'h7fff));
      send_vertex(make_vertex(-1, -1, -1, 16'hffff));
      send_vertex(make_vertex(1, 1, 1, 16'hfffe));
      send_vertex(make_vertex(-32768, 32767, 1, 16'h0001));
      send_vertex(make_vertex(3, 4, 0, 16'h1234));
      send_vertex(make_vertex(-3, 0, 4, 16'hfedc));
      send_vertex(make_vertex(-32768, 0, 0, 16'h8001));
      send_vertex(make_vertex(32767, -32768, 0, 16'h00ff));
      send_vertex(make_vertex(-1, 0, 0, 16'hff00));
      send_vertex(make_vertex(0, 1, 0, 16'h0f0f));

      repeat (RANDOM_ITEMS) send_vertex(random_vertex());
      // finish the open triangle so the store is left clean
      while (board.slot != 0) send_vertex(random_vertex());
      req_valid = 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
